/* sv/thwc_pkg.sv */
// Package: shared types, constants and the octal field step for the tar header walker.
`timescale 1ns / 1ps
package thwc_pkg;

  localparam int BLOCK_BYTES = 512;
  localparam int OFS_W       = $clog2(BLOCK_BYTES);
  localparam int SUM_W       = 17;
  localparam int SKIP_W      = 24;
  localparam int SIZE_W      = 32;
  localparam int COUNT_W     = 32;

  localparam logic [OFS_W-1:0] LAST_OFS = OFS_W'(BLOCK_BYTES - 1);
  localparam logic [OFS_W-1:0] NAME_OFS = '0;
  localparam logic [OFS_W-1:0] CK_FIRST = OFS_W'(148);
  localparam logic [OFS_W-1:0] CK_END   = OFS_W'(156);
  localparam logic [OFS_W-1:0] SZ_FIRST = OFS_W'(124);
  localparam logic [OFS_W-1:0] SZ_END   = OFS_W'(136);

  localparam logic [7:0] SPACE_CHAR = 8'd32;
  localparam logic [7:0] DIGIT_LO   = 8'd48;
  localparam logic [7:0] DIGIT_HI   = 8'd55;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_HEADER = 2'd1,
    PH_SKIP   = 2'd2
  } thwc_phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       archive_start;
  } thwc_in_t;

  typedef struct packed {
    logic               header_ok;
    logic               name_empty;
    logic [SIZE_W-1:0]  file_size;
    logic [COUNT_W-1:0] file_count;
    logic               walk_done;
  } thwc_out_t;

  typedef struct packed {
    logic [SIZE_W-1:0] value;
    logic              begun;
    logic              stop;
  } thwc_oct_t;

  localparam thwc_oct_t OCT_CLEAR = '{value: '0, begun: 1'b0, stop: 1'b0};

  // One byte of an octal field: skip leading spaces, shift in digits, stop on anything else.
  function automatic thwc_oct_t octal_step(thwc_oct_t cur, logic [7:0] b);
    thwc_oct_t r;
    r = cur;
    if (cur.stop) begin
      r = cur;
    end else if (b == SPACE_CHAR && !cur.begun) begin
      r = cur;
    end else if (b >= DIGIT_LO && b <= DIGIT_HI) begin
      r.value = {cur.value[SIZE_W-4:0], b[2:0]};
      r.begun = 1'b1;
    end else begin
      r.begun = 1'b1;
      r.stop  = 1'b1;
    end
    return r;
  endfunction

endpackage

/* sv/thwc_walk.sv */
// Input register and per-byte header walk: checksum sum, octal parsers, block skip, file count.
`timescale 1ns / 1ps
module thwc_walk (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  thwc_pkg::thwc_in_t in_data,
  input  logic               res_full,
  output logic               res_push,
  output thwc_pkg::thwc_out_t res_word
);

  localparam int OFS_W   = thwc_pkg::OFS_W;
  localparam int SUM_W   = thwc_pkg::SUM_W;
  localparam int SKIP_W  = thwc_pkg::SKIP_W;
  localparam int SIZE_W  = thwc_pkg::SIZE_W;
  localparam int COUNT_W = thwc_pkg::COUNT_W;

  logic                  v_r, v_nxt;
  thwc_pkg::thwc_in_t    in_r;
  logic                  accept, fire;

  thwc_pkg::thwc_phase_t phase_r, phase_nxt;
  logic [OFS_W-1:0]      ofs_r, ofs_nxt;
  logic [SUM_W-1:0]      sum_r, sum_nxt;
  thwc_pkg::thwc_oct_t   ck_r, ck_nxt;
  thwc_pkg::thwc_oct_t   sz_r, sz_nxt;
  logic [SKIP_W-1:0]     skip_r, skip_nxt;
  logic [COUNT_W-1:0]    files_r, files_nxt;
  logic                  first_r, first_nxt;
  logic                  name_zero_r, name_zero_nxt;

  assign in_stall = v_r && res_full;
  assign accept   = in_valid && !in_stall;
  assign fire     = v_r && !res_full;

  always_comb begin
    v_nxt = v_r;
    if (accept) begin
      v_nxt = 1'b1;
    end else if (fire) begin
      v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
    if (accept) begin
      in_r <= in_data;
    end
  end

  always_comb begin
    logic [7:0]        b;
    logic              ok, empty, done;
    logic [SIZE_W-1:0] size;
    logic [SKIP_W-1:0] blocks;

    b             = in_r.data_byte;
    phase_nxt     = phase_r;
    ofs_nxt       = ofs_r;
    sum_nxt       = sum_r;
    ck_nxt        = ck_r;
    sz_nxt        = sz_r;
    skip_nxt      = skip_r;
    files_nxt     = files_r;
    first_nxt     = first_r;
    name_zero_nxt = name_zero_r;
    res_push      = 1'b0;
    res_word      = '0;
    ok            = 1'b0;
    empty         = 1'b0;
    done          = 1'b0;
    size          = '0;
    blocks        = '0;

    // A start word restarts a first header at offset zero, whatever came before.
    if (in_r.archive_start) begin
      phase_nxt     = thwc_pkg::PH_HEADER;
      ofs_nxt       = '0;
      sum_nxt       = '0;
      ck_nxt        = thwc_pkg::OCT_CLEAR;
      sz_nxt        = thwc_pkg::OCT_CLEAR;
      name_zero_nxt = 1'b0;
      skip_nxt      = '0;
      files_nxt     = '0;
      first_nxt     = 1'b1;
    end

    case (phase_nxt)
      thwc_pkg::PH_SKIP: begin
        if (ofs_nxt == thwc_pkg::LAST_OFS) begin
          ofs_nxt  = '0;
          skip_nxt = skip_nxt - SKIP_W'(1);
          if (skip_nxt == '0) begin
            phase_nxt = thwc_pkg::PH_HEADER;
            sum_nxt   = '0;
            ck_nxt    = thwc_pkg::OCT_CLEAR;
            sz_nxt    = thwc_pkg::OCT_CLEAR;
            name_zero_nxt = 1'b0;
          end
        end else begin
          ofs_nxt = ofs_nxt + OFS_W'(1);
        end
      end
      thwc_pkg::PH_HEADER: begin
        if (ofs_nxt == thwc_pkg::NAME_OFS) begin
          name_zero_nxt = (b == 8'd0);
        end
        if (ofs_nxt >= thwc_pkg::CK_FIRST && ofs_nxt < thwc_pkg::CK_END) begin
          sum_nxt = sum_nxt + SUM_W'(thwc_pkg::SPACE_CHAR);
          ck_nxt  = thwc_pkg::octal_step(ck_nxt, b);
        end else begin
          sum_nxt = sum_nxt + SUM_W'(b);
        end
        if (ofs_nxt >= thwc_pkg::SZ_FIRST && ofs_nxt < thwc_pkg::SZ_END) begin
          sz_nxt = thwc_pkg::octal_step(sz_nxt, b);
        end

        if (ofs_nxt != thwc_pkg::LAST_OFS) begin
          ofs_nxt = ofs_nxt + OFS_W'(1);
        end else begin
          ok     = first_nxt || (ck_nxt.value == SIZE_W'(sum_nxt));
          empty  = name_zero_nxt;
          done   = !ok || empty;
          size   = sz_nxt.value;
          blocks = SKIP_W'(size[SIZE_W-1:OFS_W]) + SKIP_W'(|size[OFS_W-1:0]);
          if (!done) begin
            files_nxt = files_nxt + COUNT_W'(1);
          end
          res_push            = fire;
          res_word.header_ok  = ok;
          res_word.name_empty = empty;
          res_word.file_size  = size;
          res_word.file_count = files_nxt;
          res_word.walk_done  = done;

          first_nxt     = 1'b0;
          ofs_nxt       = '0;
          sum_nxt       = '0;
          ck_nxt        = thwc_pkg::OCT_CLEAR;
          sz_nxt        = thwc_pkg::OCT_CLEAR;
          name_zero_nxt = 1'b0;
          if (done) begin
            phase_nxt = thwc_pkg::PH_IDLE;
          end else begin
            skip_nxt  = blocks;
            phase_nxt = (blocks != '0) ? thwc_pkg::PH_SKIP : thwc_pkg::PH_HEADER;
          end
        end
      end
      default: begin
        phase_nxt = thwc_pkg::PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= thwc_pkg::PH_IDLE;
      ofs_r       <= '0;
      sum_r       <= '0;
      ck_r        <= thwc_pkg::OCT_CLEAR;
      sz_r        <= thwc_pkg::OCT_CLEAR;
      skip_r      <= '0;
      files_r     <= '0;
      first_r     <= 1'b1;
      name_zero_r <= 1'b0;
    end else if (fire) begin
      phase_r     <= phase_nxt;
      ofs_r       <= ofs_nxt;
      sum_r       <= sum_nxt;
      ck_r        <= ck_nxt;
      sz_r        <= sz_nxt;
      skip_r      <= skip_nxt;
      files_r     <= files_nxt;
      first_r     <= first_nxt;
      name_zero_r <= name_zero_nxt;
    end
  end

endmodule

/* sv/thwc_out_buf.sv */
// Two-word result buffer that decouples the walk from the result channel stall.
`timescale 1ns / 1ps
module thwc_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                res_push,
  input  thwc_pkg::thwc_out_t res_word,
  output logic                res_full,
  output logic                out_valid,
  input  logic                out_stall,
  output thwc_pkg::thwc_out_t out_data
);

  thwc_pkg::thwc_out_t mem_r [2];
  logic                rd_ptr_r, rd_ptr_nxt;
  logic                wr_ptr_r, wr_ptr_nxt;
  logic [1:0]          count_r, count_nxt;
  logic                pop;

  assign res_full  = (count_r == 2'd2);
  assign out_valid = (count_r != 2'd0);
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;

  always_comb begin
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    wr_ptr_nxt = res_push ? !wr_ptr_r : wr_ptr_r;
    count_nxt  = count_r;
    if (res_push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !res_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (res_push) begin
      mem_r[wr_ptr_r] <= res_word;
    end
  end

endmodule

/* sv/tar_header_walk_counter_top.sv */
// Top level: tar header walker, one archive byte per word, one result word per header.
// A result word is computed from the input register and held in the result buffer.
// One input word per cycle unless in_stall holds it off when the result buffer is full.
// Bytes of data blocks and bytes outside a walk are consumed and produce no result word.
// Reset (rst_n low, synchronous): idle until a word with archive_start, count cleared,
// first header flagged to pass unchecked, input register and result buffer empty.
`timescale 1ns / 1ps
module tar_header_walk_counter_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  thwc_pkg::thwc_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output thwc_pkg::thwc_out_t out_data
);

  // Walk-to-buffer hand-off: push a result word when the buffer has room.
  logic                res_push;
  logic                res_full;
  thwc_pkg::thwc_out_t res_word;

  // Hold each byte in the input register, then advance the walk state from that register.
  thwc_walk u_walk (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .res_full (res_full),
    .res_push (res_push),
    .res_word (res_word)
  );

  // Buffer two result words so a stalled result does not block the byte stream at once.
  thwc_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_push  (res_push),
    .res_word  (res_word),
    .res_full  (res_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* tb/sv/tar_header_walk_counter_top_test.sv */
`timescale 1ns / 1ps
// Testbench for the tar header walker: byte-stream archives in, per-header results checked.
module tar_header_walk_counter_top_test;
  import thwc_pkg::*;

  // Header field offsets, inclusive on both ends.
  localparam int SIZE_FIELD_LO = 124;
  localparam int SIZE_FIELD_HI = 135;
  localparam int SUM_FIELD_LO  = 148;
  localparam int SUM_FIELD_HI  = 155;

  localparam logic [7:0] ASCII_SPACE = 8'h20;
  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_SEVEN = 8'h37;

  // Long receiver hold-off: longer than several size-0 headers back to back,
  // so finished headers pile up inside the block and it stalls its input.
  localparam int LONG_HOLD = 3000;

  // Slowest legal run is about 135k words, each behind the longest sender gap at worst;
  // allow several times that.
  localparam int LIMIT_NS = 400_000_000;

  // How a header's size field is laid out.
  typedef enum int {
    SIZE_PLAIN,    // eleven octal digits and a NUL
    SIZE_PADDED,   // leading spaces, digits, trailing space
    SIZE_JUNK,     // any mix of spaces, digits 0..9 and raw bytes
    SIZE_WRAP      // twelve octal digits, overflows 32 bits
  } size_form_e;

  // How a header's checksum field is laid out.
  typedef enum int {
    SUM_PLAIN,     // six digits, NUL, space
    SUM_PADDED,    // space, six digits, space
    SUM_LONG,      // eight digits, no terminator
    SUM_WRONG,     // well formed but off from the real sum
    SUM_GARBLED    // random bytes
  } sum_form_e;

  // Tracks the archive walk byte by byte and holds the header results still due.
  class header_walk_tracker;
    thwc_phase_t        walk_phase;
    logic [OFS_W-1:0]   hdr_pos;
    logic [SUM_W-1:0]   hdr_sum;
    thwc_oct_t          sum_field;
    thwc_oct_t          len_field;
    logic [SKIP_W-1:0]  data_blocks;
    logic [COUNT_W-1:0] file_total;
    bit                 unchecked_next;
    bit                 name_blank;
    thwc_out_t          headers_due[$];
    int                 headers_closed;
    int                 bad_words;

    function new();
      open_header();
      walk_phase     = PH_IDLE;
      data_blocks    = '0;
      file_total     = '0;
      unchecked_next = 1'b1;
      headers_closed = 0;
      bad_words      = 0;
    endfunction

    function void open_header();
      walk_phase = PH_HEADER;
      hdr_pos    = '0;
      hdr_sum    = '0;
      sum_field  = '{value: '0, begun: 1'b0, stop: 1'b0};
      len_field  = '{value: '0, begun: 1'b0, stop: 1'b0};
      name_blank = 1'b0;
    endfunction

    function thwc_oct_t next_octal(thwc_oct_t f, logic [7:0] b);
      thwc_oct_t n;
      n = f;
      if (f.stop || (b == ASCII_SPACE && !f.begun)) return n;
      n.begun = 1'b1;
      if (b >= ASCII_ZERO && b <= ASCII_SEVEN) begin
        n.value = (f.value << 3) + 32'(b - ASCII_ZERO);
      end else begin
        n.stop = 1'b1;
      end
      return n;
    endfunction

    function void take_word(thwc_in_t w);
      logic [7:0]  b;
      thwc_out_t   res;
      logic [31:0] blocks;
      b = w.data_byte;
      if (w.archive_start) begin
        open_header();
        data_blocks    = '0;
        file_total     = '0;
        unchecked_next = 1'b1;
      end
      if (walk_phase == PH_SKIP) begin
        if (hdr_pos == OFS_W'(BLOCK_BYTES - 1)) begin
          hdr_pos     = '0;
          data_blocks = data_blocks - SKIP_W'(1);
          if (data_blocks == '0) open_header();
        end else begin
          hdr_pos = hdr_pos + OFS_W'(1);
        end
        return;
      end
      if (walk_phase != PH_HEADER) return;

      if (hdr_pos == '0) name_blank = (b == 8'h00);
      if (int'(hdr_pos) >= SUM_FIELD_LO && int'(hdr_pos) <= SUM_FIELD_HI) begin
        hdr_sum   = hdr_sum + SUM_W'(ASCII_SPACE);
        sum_field = next_octal(sum_field, b);
      end else begin
        hdr_sum = hdr_sum + SUM_W'(b);
      end
      if (int'(hdr_pos) >= SIZE_FIELD_LO && int'(hdr_pos) <= SIZE_FIELD_HI)
        len_field = next_octal(len_field, b);
      if (hdr_pos != OFS_W'(BLOCK_BYTES - 1)) begin
        hdr_pos = hdr_pos + OFS_W'(1);
        return;
      end

      res.header_ok  = unchecked_next || (sum_field.value == 32'(hdr_sum));
      res.name_empty = name_blank;
      res.file_size  = len_field.value;
      res.walk_done  = !res.header_ok || name_blank;
      if (!res.walk_done) file_total = file_total + COUNT_W'(1);
      res.file_count = file_total;
      headers_due.push_back(res);
      headers_closed++;

      unchecked_next = 1'b0;
      blocks = (len_field.value >> OFS_W) + 32'(len_field.value[OFS_W-1:0] != '0);
      open_header();
      if (res.walk_done) begin
        walk_phase = PH_IDLE;
      end else begin
        data_blocks = blocks[SKIP_W-1:0];
        if (data_blocks != '0) walk_phase = PH_SKIP;
      end
    endfunction

    function void check_word(thwc_out_t got);
      thwc_out_t want;
      if (headers_due.size() == 0) begin
        bad_words++;
        if (bad_words <= 10)
          $display("result word with no header pending: ok=%0b empty=%0b size=%0h count=%0d done=%0b",
                   got.header_ok, got.name_empty, got.file_size, got.file_count, got.walk_done);
        return;
      end
      want = headers_due.pop_front();
      if (got.header_ok !== want.header_ok || got.name_empty !== want.name_empty ||
          got.file_size !== want.file_size || got.file_count !== want.file_count ||
          got.walk_done !== want.walk_done) begin
        bad_words++;
        if (bad_words <= 10) begin
          $display("header result mismatch: expected ok=%0b empty=%0b size=%0h count=%0d done=%0b",
                   want.header_ok, want.name_empty, want.file_size, want.file_count,
                   want.walk_done);
          $display("                        actual   ok=%0b empty=%0b size=%0h count=%0d done=%0b",
                   got.header_ok, got.name_empty, got.file_size, got.file_count, got.walk_done);
        end
      end
    endfunction

    function int pending();
      return headers_due.size();
    endfunction

    function bit walking();
      return walk_phase != PH_IDLE;
    endfunction

    function int blocks_ahead();
      return (walk_phase == PH_SKIP) ? int'(data_blocks) : 0;
    endfunction
  endclass

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  thwc_in_t   in_data   = '0;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  thwc_out_t  out_data;

  header_walk_tracker sb = new();

  // Header image built by build_header, sent by send_block.
  logic [7:0] hdr_bytes [BLOCK_BYTES];
  // steady: sender offers words back to back; hold_asked: receiver starts a long hold-off.
  bit         steady     = 1'b0;
  bit         hold_asked = 1'b0;

  tar_header_walk_counter_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Offer one word and hold it until the block takes it. Most words go out with no gap,
  // some after a short gap, a few after a long one. in_valid gets only one assignment per edge.
  task automatic send_word(input logic [7:0] b, input bit start);
    thwc_in_t w;
    int       r;
    int       gap;
    w.data_byte     = b;
    w.archive_start = start;
    r   = $urandom_range(0, 99);
    gap = (steady || r < 62) ? 0 : (r < 93) ? $urandom_range(1, 3) : $urandom_range(8, 24);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    sb.take_word(w);
  endtask

  // Send the header image; stop short before byte 'cut' when cut is not negative.
  task automatic send_block(input bit start, input int cut);
    int stop_at;
    stop_at = (cut < 0) ? BLOCK_BYTES : cut;
    for (int i = 0; i < stop_at; i++) send_word(hdr_bytes[i], start && i == 0);
  endtask

  // Pause the sender until every header result due has come out.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Write an octal field: 'lead' spaces, 'digits' digits of v, then fill bytes.
  task automatic put_octal(input int at, input int width, input int lead, input int digits,
                           input logic [63:0] v, input logic [7:0] fill);
    for (int i = 0; i < width; i++) begin
      if (i < lead) begin
        hdr_bytes[at+i] = ASCII_SPACE;
      end else if (i < lead + digits) begin
        hdr_bytes[at+i] = ASCII_ZERO + 8'((v >> (3 * (lead + digits - 1 - i))) & 64'd7);
      end else begin
        hdr_bytes[at+i] = fill;
      end
    end
  endtask

  // Build a header: printable name, mostly zero tail with some raw bytes,
  // then the size field and a checksum field in the requested forms.
  task automatic build_header(input bit empty_name, input size_form_e sform,
                              input logic [31:0] len, input sum_form_e cform);
    int lead;
    int acc;
    int r;
    foreach (hdr_bytes[i])
      hdr_bytes[i] = (i < 100) ? 8'($urandom_range(33, 126)) :
                     ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00;
    hdr_bytes[0] = empty_name ? 8'h00 : 8'($urandom_range(1, 255));
    case (sform)
      SIZE_PLAIN: begin
        put_octal(SIZE_FIELD_LO, 12, 0, 11, len, 8'h00);
      end
      SIZE_PADDED: begin
        lead = $urandom_range(1, 3);
        put_octal(SIZE_FIELD_LO, 12, lead, 11 - lead, len, ASCII_SPACE);
      end
      SIZE_JUNK: begin
        for (int i = SIZE_FIELD_LO; i <= SIZE_FIELD_HI; i++) begin
          r = $urandom_range(0, 3);
          hdr_bytes[i] = (r == 0) ? ASCII_SPACE : (r == 1) ? 8'($urandom_range(48, 57)) :
                         (r == 2) ? 8'($urandom_range(48, 55)) : 8'($urandom);
        end
      end
      default: begin
        for (int i = SIZE_FIELD_LO; i <= SIZE_FIELD_HI; i++)
          hdr_bytes[i] = 8'($urandom_range(48, 55));
      end
    endcase
    // Sum as the walker does: the checksum field counts as spaces.
    acc = 0;
    for (int i = 0; i < BLOCK_BYTES; i++)
      acc += (i >= SUM_FIELD_LO && i <= SUM_FIELD_HI) ? int'(ASCII_SPACE) : int'(hdr_bytes[i]);
    case (cform)
      SUM_PLAIN: begin
        put_octal(SUM_FIELD_LO, 8, 0, 6, 64'(acc), 8'h00);
        hdr_bytes[SUM_FIELD_HI] = ASCII_SPACE;
      end
      SUM_PADDED:  put_octal(SUM_FIELD_LO, 8, 1, 6, 64'(acc), ASCII_SPACE);
      SUM_LONG:    put_octal(SUM_FIELD_LO, 8, 0, 8, 64'(acc), 8'h00);
      SUM_WRONG:   put_octal(SUM_FIELD_LO, 8, 0, 6, 64'(acc ^ $urandom_range(1, 63)), 8'h00);
      default: begin
        for (int i = SUM_FIELD_LO; i <= SUM_FIELD_HI; i++)
          hdr_bytes[i] = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(32, 57)) : 8'($urandom);
      end
    endcase
  endtask

  // One archive of up to n_files entries. With 'broken' set, odd field forms,
  // cut-short headers and huge sizes show up; those end with a restart later.
  task automatic send_archive(input int n_files, input bit broken);
    int          r;
    logic [31:0] len;
    size_form_e  sform;
    sum_form_e   cform;
    for (int f = 0; f < n_files; f++) begin
      r     = $urandom_range(0, 99);
      sform = (r < 70) ? SIZE_PLAIN : (r < 85 || !broken) ? SIZE_PADDED :
              (r < 93) ? SIZE_JUNK : SIZE_WRAP;
      r     = $urandom_range(0, 99);
      len   = (r < 25) ? 32'd0 : (r < 80) ? 32'($urandom_range(1, 1100)) :
              (r < 92 || !broken) ? 32'(BLOCK_BYTES * $urandom_range(1, 2)) :
              32'($urandom_range(1, 20000));
      r     = $urandom_range(0, 99);
      if (f == 0) begin
        cform = (r < 80 || !broken) ? SUM_PLAIN : (r < 90) ? SUM_WRONG : SUM_GARBLED;
      end else begin
        cform = (r < 45) ? SUM_PLAIN : (r < 65) ? SUM_PADDED : (r < 85 || !broken) ? SUM_LONG :
                (r < 93) ? SUM_WRONG : SUM_GARBLED;
      end
      build_header(1'b0, sform, len, cform);
      if (broken && $urandom_range(0, 19) == 0) begin
        send_block(f == 0, $urandom_range(1, BLOCK_BYTES - 1));
        return;
      end
      send_block(f == 0, -1);
      if (!sb.walking()) return;
      // Too many data blocks to send: drop part way and let the next start cut in.
      if (sb.blocks_ahead() > 3) begin
        repeat ($urandom_range(1, 700)) send_word(8'($urandom), 1'b0);
        return;
      end
      while (sb.blocks_ahead() != 0) send_word(8'($urandom), 1'b0);
    end
    // Close the walk: zero block, a named-empty header, or a bad checksum.
    r = $urandom_range(0, 99);
    if (r < 70) begin
      foreach (hdr_bytes[i]) hdr_bytes[i] = 8'h00;
    end else begin
      build_header(r < 88, SIZE_PLAIN, 32'd0, (r < 88) ? SUM_PLAIN : SUM_WRONG);
    end
    send_block(1'b0, -1);
  endtask

  // Result side: random stall pattern with quiet stretches, plus one long hold-off on request.
  initial begin : result_sink
    int run_left;
    int hold_left;
    int r;
    run_left  = 0;
    hold_left = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_asked) begin
        hold_asked = 1'b0;
        hold_left  = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (run_left > 0) begin
        run_left--;
      end else begin
        r = $urandom_range(0, 99);
        out_stall <= (r >= 55);
        run_left = (r < 10) ? $urandom_range(100, 400) : (r < 55) ? $urandom_range(0, 15) :
                   (r < 90) ? $urandom_range(0, 2) : $urandom_range(10, 40);
      end
    end
  end

  // Check every result word taken, using values from before the edge.
  initial begin : result_check
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_stall === 1'b0) sb.check_word(out_data);
    end
  end

  initial begin : stimulus
    int k;
    int guard;
    k     = 0;
    guard = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Bytes before any start: ignored.
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'($urandom), 1'b0);

    // First header passes even with a wrong checksum.
    build_header(1'b0, SIZE_PLAIN, 32'd0, SUM_WRONG);
    send_block(1'b1, -1);
    // One-byte file: one data block, alternate extreme bytes.
    build_header(1'b0, SIZE_PADDED, 32'd1, SUM_PLAIN);
    send_block(1'b0, -1);
    while (sb.blocks_ahead() != 0) begin
      send_word(k[0] ? 8'hFF : 8'h00, 1'b0);
      k++;
    end
    // Size of exactly one block, checksum in eight digits.
    build_header(1'b0, SIZE_PLAIN, 32'd512, SUM_LONG);
    send_block(1'b0, -1);
    while (sb.blocks_ahead() != 0) send_word(8'($urandom), 1'b0);
    // Bad checksum on a later header ends the walk; size still reported.
    build_header(1'b0, SIZE_PLAIN, 32'o777, SUM_WRONG);
    send_block(1'b0, -1);
    // Bytes after the walk ended: ignored.
    send_word(8'hFF, 1'b0);
    send_word(8'h00, 1'b0);

    // Empty name on the first header, junk size field.
    build_header(1'b1, SIZE_JUNK, 32'd0, SUM_GARBLED);
    send_block(1'b1, -1);

    // Size field overflowing 32 bits; restart while skipping its data.
    build_header(1'b0, SIZE_WRAP, 32'd0, SUM_PLAIN);
    send_block(1'b1, -1);
    repeat (300) send_word(8'($urandom), 1'b0);

    // Restart mid-header, then two start words back to back.
    build_header(1'b0, SIZE_PLAIN, 32'd100, SUM_PLAIN);
    send_block(1'b1, 200);
    send_word(8'h41, 1'b1);
    build_header(1'b0, SIZE_PLAIN, 32'd0, SUM_PLAIN);
    send_block(1'b1, -1);
    build_header(1'b0, SIZE_PLAIN, 32'd0, SUM_PADDED);
    send_block(1'b0, -1);
    foreach (hdr_bytes[i]) hdr_bytes[i] = 8'h00;
    send_block(1'b0, -1);
    wait_for_results();

    // Receiver holds off while size-0 headers stream in back to back.
    hold_asked = 1'b1;
    steady     = 1'b1;
    for (int f = 0; f < 8; f++) begin
      build_header(1'b0, SIZE_PLAIN, 32'd0, SUM_PLAIN);
      send_block(f == 0, -1);
    end
    steady = 1'b0;
    wait_for_results();

    // Random archives, mostly well formed, until several dozen headers closed.
    while (sb.headers_closed < 48) begin
      steady = ($urandom_range(0, 3) == 0);
      send_archive($urandom_range(1, 5), $urandom_range(0, 1) == 1);
      if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 40)) send_word(8'($urandom), 1'b0);
      if ($urandom_range(0, 9) == 0) wait_for_results();
    end

    // Drain: wait for the last result, then keep watching for stray words before the verdict.
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
      guard++;
    end while (sb.pending() != 0 && guard < 10000);
    if (sb.pending() != 0) begin
      $display("%0d header results never arrived", sb.pending());
      $display("tb: failure");
    end else begin
      repeat (16) @(posedge clk);
      if (sb.bad_words == 0) begin
        $display("tb: success");
      end else begin
        $display("tb: failure");
      end
    end
    $finish;
  end

  initial begin : run_limit
    #(LIMIT_NS);
    $display("tb: failure");
    $finish;
  end

endmodule

/* sim.f */
sv/thwc_pkg.sv
sv/thwc_walk.sv
sv/thwc_out_buf.sv
sv/tar_header_walk_counter_top.sv
tb/sv/tar_header_walk_counter_top_test.sv
